// ===== rtl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They expand to nothing
// when SYNTHESIS is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, switched off while reset is asserted (active low).
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Checked property that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define ASSERT_CLK_RST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)

`endif

`endif

// ===== rtl/acu_pkg.sv =====
// ============================================================================
// Accumulator CPU execute unit package
// Transaction types and operation codes of the execute unit.
// ============================================================================
package acu_pkg;

    // One decoded instruction.
    typedef struct packed {
        logic [5:0]  op;
        logic [15:0] operand_value;
        logic [15:0] next_pc;
    } t_in;

    // Architectural result of one instruction.
    typedef struct packed {
        logic [15:0] new_pc;
        logic [15:0] acc_out;
        logic [15:0] index_out;
        logic [15:0] stack_out;
        logic [3:0]  flags_out;
        logic        store_valid;
        logic [15:0] store_address;
        logic [15:0] store_data;
        logic        store_is_byte;
        logic        illegal;
    } t_out;

    // Operation codes.
    localparam logic [5:0] OP_NOP     = 6'd0;
    localparam logic [5:0] OP_MOVFA   = 6'd1;
    localparam logic [5:0] OP_MOVAF   = 6'd2;
    localparam logic [5:0] OP_MOVSPA  = 6'd3;
    localparam logic [5:0] OP_MOVASP  = 6'd4;
    localparam logic [5:0] OP_NEG_A   = 6'd5;
    localparam logic [5:0] OP_NEG_X   = 6'd6;
    localparam logic [5:0] OP_ASL_A   = 6'd7;
    localparam logic [5:0] OP_ASL_X   = 6'd8;
    localparam logic [5:0] OP_ASR_A   = 6'd9;
    localparam logic [5:0] OP_ASR_X   = 6'd10;
    localparam logic [5:0] OP_NOT_A   = 6'd11;
    localparam logic [5:0] OP_NOT_X   = 6'd12;
    localparam logic [5:0] OP_ROL_A   = 6'd13;
    localparam logic [5:0] OP_ROL_X   = 6'd14;
    localparam logic [5:0] OP_ROR_A   = 6'd15;
    localparam logic [5:0] OP_ROR_X   = 6'd16;
    localparam logic [5:0] OP_BR      = 6'd17;
    localparam logic [5:0] OP_BRLE    = 6'd18;
    localparam logic [5:0] OP_BRLT    = 6'd19;
    localparam logic [5:0] OP_BREQ    = 6'd20;
    localparam logic [5:0] OP_BRNE    = 6'd21;
    localparam logic [5:0] OP_BRGE    = 6'd22;
    localparam logic [5:0] OP_BRGT    = 6'd23;
    localparam logic [5:0] OP_BRV     = 6'd24;
    localparam logic [5:0] OP_BRC     = 6'd25;
    localparam logic [5:0] OP_LDW_A   = 6'd26;
    localparam logic [5:0] OP_LDW_X   = 6'd27;
    localparam logic [5:0] OP_LDB_A   = 6'd28;
    localparam logic [5:0] OP_LDB_X   = 6'd29;
    localparam logic [5:0] OP_STW_A   = 6'd30;
    localparam logic [5:0] OP_STW_X   = 6'd31;
    localparam logic [5:0] OP_STB_A   = 6'd32;
    localparam logic [5:0] OP_STB_X   = 6'd33;
    localparam logic [5:0] OP_CPW_A   = 6'd34;
    localparam logic [5:0] OP_CPW_X   = 6'd35;
    localparam logic [5:0] OP_CPB_A   = 6'd36;
    localparam logic [5:0] OP_CPB_X   = 6'd37;
    localparam logic [5:0] OP_ADD_A   = 6'd38;
    localparam logic [5:0] OP_ADD_X   = 6'd39;
    localparam logic [5:0] OP_SUB_A   = 6'd40;
    localparam logic [5:0] OP_SUB_X   = 6'd41;
    localparam logic [5:0] OP_AND_A   = 6'd42;
    localparam logic [5:0] OP_AND_X   = 6'd43;
    localparam logic [5:0] OP_OR_A    = 6'd44;
    localparam logic [5:0] OP_OR_X    = 6'd45;
    localparam logic [5:0] OP_XOR_A   = 6'd46;
    localparam logic [5:0] OP_XOR_X   = 6'd47;
    localparam logic [5:0] OP_ADDSP   = 6'd48;
    localparam logic [5:0] OP_SUBSP   = 6'd49;

    // Value of a negated word that overflows.
    localparam logic [15:0] MIN_WORD = 16'h8000;

endpackage

// ===== rtl/accumulator_cpu_execute_unit.sv =====
// ============================================================================
// Accumulator CPU execute unit
// Executes one decoded instruction per transaction and keeps A, X, SP and
// the NZVC flags.
// ============================================================================
// The unit takes one instruction every clock cycle unless the result side
// stalls: the instruction is captured in an input register, then one pass of
// ALU and flag logic updates the architectural registers and the result
// register on the same edge, so the next instruction always sees the state
// left by the one before it. When the result side stalls, the input side
// keeps taking one more instruction into its input register before it stalls.
`include "assert_macros.svh"

module accumulator_cpu_execute_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  acu_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output acu_pkg::t_out o_out_data
);
    import acu_pkg::*;

    // Pipeline registers.
    logic        r_in_valid;
    t_in         r_in;
    logic        r_out_valid;
    t_out        r_out;

    // Architectural state.
    logic [15:0] r_acc;
    logic [15:0] r_idx;
    logic [15:0] r_sp;
    logic [3:0]  r_flags;

    // Next state from the execute pass.
    logic [15:0] n_acc;
    logic [15:0] n_idx;
    logic [15:0] n_sp;
    logic [3:0]  n_flags;
    t_out        n_out;

    // Execute datapath signals.
    logic        w_out_free;
    logic        w_fire;
    logic        w_in_take;
    logic        w_on_x;
    logic [15:0] w_a;
    logic [15:0] w_opr;
    logic [16:0] w_sum_add;
    logic [16:0] w_sum_sub;
    logic [7:0]  w_diff8;
    logic        w_v_add;
    logic        w_v_sub;
    logic [15:0] w_res;
    logic        w_wr;
    logic        w_take;

    // Handshake: the result register frees up when empty or being taken.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Register select: shift group uses even codes for X, the rest odd codes.
    always_comb begin
        if (r_in.op >= OP_NEG_A && r_in.op <= OP_ROR_X) begin
            w_on_x = !r_in.op[0];
        end else begin
            w_on_x = r_in.op[0];
        end
    end

    // Shared arithmetic.
    assign w_a       = w_on_x ? r_idx : r_acc;
    assign w_opr     = r_in.operand_value;
    assign w_sum_add = {1'b0, w_a} + {1'b0, w_opr};
    assign w_sum_sub = {1'b0, w_a} + {1'b0, ~w_opr} + 17'd1;
    assign w_diff8   = w_a[7:0] - w_opr[7:0];
    assign w_v_add   = (w_a[15] ^ w_sum_add[15]) & (w_opr[15] ^ w_sum_add[15]);
    assign w_v_sub   = (w_a[15] ^ w_sum_sub[15]) & (~w_opr[15] ^ w_sum_sub[15]);

    // Instruction decode and execute.
    always_comb begin
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_sp    = r_sp;
        n_flags = r_flags;
        w_res   = w_a;
        w_wr    = 1'b0;
        w_take  = 1'b0;
        n_out   = '0;

        case (r_in.op)
            OP_NOP: begin
            end
            OP_MOVFA: begin
                n_acc = {12'd0, r_flags};
            end
            OP_MOVAF: begin
                n_flags = r_acc[3:0];
            end
            OP_MOVSPA: begin
                n_acc = r_sp;
            end
            OP_MOVASP: begin
                n_sp = r_acc;
            end
            OP_NEG_A, OP_NEG_X: begin
                w_res   = 16'd0 - w_a;
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, w_res == MIN_WORD, w_a == 16'd0};
            end
            OP_ASL_A, OP_ASL_X: begin
                w_res   = {w_a[14:0], 1'b0};
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, w_a[15] ^ w_res[15], w_a[15]};
            end
            OP_ASR_A, OP_ASR_X: begin
                w_res   = {w_a[15], w_a[15:1]};
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, 1'b0, w_a[0]};
            end
            OP_NOT_A, OP_NOT_X: begin
                w_res   = ~w_a;
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, r_flags[1:0]};
            end
            OP_ROL_A, OP_ROL_X: begin
                w_res   = {w_a[14:0], r_flags[0]};
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, r_flags[1], w_a[15]};
            end
            OP_ROR_A, OP_ROR_X: begin
                w_res   = {r_flags[0], w_a[15:1]};
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, r_flags[1], w_a[0]};
            end
            OP_BR: begin
                w_take = 1'b1;
            end
            OP_BRLE: begin
                w_take = r_flags[3] | r_flags[2];
            end
            OP_BRLT: begin
                w_take = r_flags[3];
            end
            OP_BREQ: begin
                w_take = r_flags[2];
            end
            OP_BRNE: begin
                w_take = !r_flags[2];
            end
            OP_BRGE: begin
                w_take = !r_flags[3];
            end
            OP_BRGT: begin
                w_take = !r_flags[3] && !r_flags[2];
            end
            OP_BRV: begin
                w_take = r_flags[1];
            end
            OP_BRC: begin
                w_take = r_flags[0];
            end
            OP_LDW_A, OP_LDW_X: begin
                w_res   = w_opr;
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, r_flags[1:0]};
            end
            OP_LDB_A, OP_LDB_X: begin
                w_res   = {8'd0, w_opr[7:0]};
                w_wr    = 1'b1;
                n_flags = {1'b0, w_res == 16'd0, r_flags[1:0]};
            end
            OP_STW_A, OP_STW_X: begin
                n_out.store_valid   = 1'b1;
                n_out.store_address = w_opr;
                n_out.store_data    = w_a;
            end
            OP_STB_A, OP_STB_X: begin
                n_out.store_valid   = 1'b1;
                n_out.store_address = w_opr;
                n_out.store_data    = {8'd0, w_a[7:0]};
                n_out.store_is_byte = 1'b1;
            end
            OP_CPW_A, OP_CPW_X: begin
                // Signed compare: N is corrected by the overflow.
                n_flags = {w_sum_sub[15] ^ w_v_sub, w_sum_sub[15:0] == 16'd0,
                           w_v_sub, w_sum_sub[16]};
            end
            OP_CPB_A, OP_CPB_X: begin
                n_flags = {w_diff8[7], w_diff8 == 8'd0, 2'b00};
            end
            OP_ADD_A, OP_ADD_X: begin
                w_res   = w_sum_add[15:0];
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, w_v_add, w_sum_add[16]};
            end
            OP_SUB_A, OP_SUB_X: begin
                w_res   = w_sum_sub[15:0];
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, w_v_sub, w_sum_sub[16]};
            end
            OP_AND_A, OP_AND_X: begin
                w_res   = w_a & w_opr;
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, r_flags[1:0]};
            end
            OP_OR_A, OP_OR_X: begin
                w_res   = w_a | w_opr;
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, r_flags[1:0]};
            end
            OP_XOR_A, OP_XOR_X: begin
                w_res   = w_a ^ w_opr;
                w_wr    = 1'b1;
                n_flags = {w_res[15], w_res == 16'd0, r_flags[1:0]};
            end
            OP_ADDSP: begin
                n_sp = r_sp + w_opr;
            end
            OP_SUBSP: begin
                n_sp = r_sp - w_opr;
            end
            default: begin
                n_out.illegal = 1'b1;
            end
        endcase

        // Write back to the selected register.
        if (w_wr) begin
            if (w_on_x) begin
                n_idx = w_res;
            end else begin
                n_acc = w_res;
            end
        end

        n_out.new_pc    = w_take ? w_opr : r_in.next_pc;
        n_out.acc_out   = n_acc;
        n_out.index_out = n_idx;
        n_out.stack_out = n_sp;
        n_out.flags_out = n_flags;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= 16'd0;
            r_idx       <= 16'd0;
            r_sp        <= 16'd0;
            r_flags     <= 4'd0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_acc       <= n_acc;
                r_idx       <= n_idx;
                r_sp        <= n_sp;
                r_flags     <= n_flags;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The input side only stalls on a held instruction.
    `ASSERT_CLK_RST(a_stall_needs_item, i_clk, i_rst_n, o_in_stall |-> r_in_valid)
    // A result only appears from a held instruction.
    `ASSERT_CLK_RST(a_no_phantom, i_clk, i_rst_n,
        (!r_in_valid && !r_out_valid) |=> !r_out_valid)
    // The pending result reflects the architectural registers.
    `ASSERT_CLK_RST(a_out_matches_state, i_clk, i_rst_n,
        r_out_valid |-> (r_out.acc_out == r_acc && r_out.index_out == r_idx &&
                         r_out.stack_out == r_sp && r_out.flags_out == r_flags))
    // An illegal instruction leaves the state unchanged and writes nothing.
    `ASSERT_CLK_RST(a_illegal_inert, i_clk, i_rst_n,
        (w_fire && n_out.illegal) |=> ($stable(r_acc) && $stable(r_idx) &&
            $stable(r_sp) && $stable(r_flags) && !r_out.store_valid))

endmodule
